/* sv/bmrs_pkg.sv */
`default_nettype none

package bmrs_pkg;

    // Default document count of the per-document stores
    localparam int unsigned DEFAULT_MAX_DOCS = 65536;

    // Widths of the fixed-point datapath
    localparam int unsigned QUOT_BITS  = 16;  // tf*1.9/denominator in Q.15, always below 2^16
    localparam int unsigned DEN_BITS   = 62;  // 100 * denominator in Q.24
    localparam int unsigned RATIO_BITS = 56;  // length * inverse mean length, Q.24

    // Readability term: floor((20000 - R) * 2^12 / 125), computed as
    // floor(y / 125) - READ_OFFS with y = READ_BIAS - R * 2^12 kept positive.
    localparam logic [27:0] READ_BIAS   = 28'd268431375;
    localparam logic [31:0] READ_OFFS   = 32'd1492091;
    // Reciprocal of 125 scaled by 2^35, exact for every y below 2^28
    localparam logic [28:0] RECIP_125   = 29'd274877907;
    localparam int unsigned RECIP_SHIFT = 35;

    // Reset value of the reciprocal mean length register (1.0 in Q8.24)
    localparam logic [31:0] IML_RESET = 32'd16777216;

    // Register indexes of the configuration channel
    localparam logic CFG_IDF = 1'b0;
    localparam logic CFG_IML = 1'b1;

    // Operation codes
    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_SCORE = 2'd1,
        OP_READ  = 2'd2
    } op_t;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FETCH,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_DEN,
        ST_DIV,
        ST_ACC,
        ST_DONE
    } state_t;

    // Divider request and response
    typedef struct packed {
        logic                start;
        logic [15:0]         tf;
        logic [DEN_BITS-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic                 done;
        logic [QUOT_BITS-1:0] quot;
    } div_rsp_t;

endpackage

`default_nettype wire

/* sv/bmrs_ram.sv */
`default_nettype none

module bmrs_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

`default_nettype wire

/* sv/bmrs_divider.sv */
`default_nettype none

module bmrs_divider (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire bmrs_pkg::div_req_t req,
    output bmrs_pkg::div_rsp_t      rsp
);

    localparam int unsigned DW = bmrs_pkg::DEN_BITS;
    localparam int unsigned QW = bmrs_pkg::QUOT_BITS;

    logic [DW-1:0]          rem_reg;
    logic [DW-1:0]          den_reg;
    logic [QW-1:0]          quot_reg;
    logic [$clog2(QW)-1:0]  cnt_reg;
    logic                   busy_reg;
    logic                   done_reg;

    logic [DW:0]            trial;
    logic [DW:0]            diff;
    logic                   fits;
    logic [23:0]            num_top;

    // Numerator is tf*190*2^39; its top part tf*190*2^23 is already below
    // the denominator, so 16 restoring steps give the whole quotient.
    assign num_top = 24'(req.tf * 16'd190);
    assign trial   = {rem_reg, 1'b0};
    assign diff    = trial - {1'b0, den_reg};
    assign fits    = trial >= {1'b0, den_reg};

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= ($clog2(QW))'(QW - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // One quotient bit per cycle
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg  <= DW'({num_top, 23'b0});
            den_reg  <= req.den;
            quot_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg  <= fits ? diff[DW-1:0] : trial[DW-1:0];
            quot_reg <= {quot_reg[QW-2:0], fits};
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;

endmodule

`default_nettype wire

/* sv/bm25_readability_scorer.sv */
// BM25 readability scorer.
// Input stream: s_axis_* carries one operation per transaction (load a
// document's length and readability, score a posting, read a score).
// Output stream: m_axis_* returns exactly one result per input transaction,
// in order: the posting's added score and the document's total.
// Configuration channel cfg_*: writes the term idf and the reciprocal mean
// document length; always ready. It must be written only while the block
// is idle; the block itself does not enforce this. One operation is in
// flight at a time. Load and read go through the fetch state; a score
// runs the split length multiply, the 16-step serial divider and ACC.
// The input is taken again once the result is in the output register, so a
// new operation runs while the previous result waits for the receiver.
// If the receiver stalls, the finished result of the next operation waits in
// the sequencer until the output register frees up.
// After reset the score memory is cleared one entry per cycle, all MAX_DOCS
// entries in turn; s_axis_tready stays low during that pass.
`default_nettype none

module bm25_readability_scorer #(
    parameter int unsigned MAX_DOCS = bmrs_pkg::DEFAULT_MAX_DOCS
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [15:0] doc_number, [31:16] term_frequency, [55:32] doc_length_in,
    // [71:56] readability_in
    input  wire logic [71:0] s_axis_tdata,
    // [1:0] operation
    input  wire logic [1:0]  s_axis_tuser,
    // result stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [31:0] posting_score, [63:32] total_score
    output logic      [63:0] m_axis_tdata,
    // configuration
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [31:0] cfg_data
);

    localparam int unsigned AW = $clog2(MAX_DOCS);
    localparam logic [24:0] DOC_LIMIT = 25'(MAX_DOCS);
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_DOCS - 1);

    bmrs_pkg::state_t state_reg, state_next;

    // configuration registers
    logic [23:0] idf_reg;
    logic [31:0] iml_reg;

    // item registers
    logic [AW-1:0] addr_reg;
    logic [15:0]   tf_reg;
    logic [23:0]   len_reg;
    logic [31:0]   score_reg;
    logic [39:0]   ratio_lo_reg;
    logic [bmrs_pkg::RATIO_BITS-1:0] ratio_reg;
    logic [21:0]   rdq_reg;
    logic [39:0]   prod_reg;
    logic [31:0]   post_reg;
    logic [31:0]   total_reg;
    logic [AW-1:0] clr_cnt_reg;
    logic          out_valid_reg;
    logic [63:0]   out_data_reg;

    // input fields
    logic [15:0]       in_doc;
    logic [15:0]       in_tf;
    logic [23:0]       in_len;
    logic [15:0]       in_rd;
    bmrs_pkg::op_t     in_op;
    logic              in_acc;
    logic              in_range;

    // memory ports
    logic          score_we;
    logic [AW-1:0] score_waddr;
    logic [31:0]   score_wdata;
    logic [31:0]   score_q;
    logic          doc_we;
    logic [23:0]   len_q;
    logic [15:0]   rd_q;

    // arithmetic
    logic [27:0]   rd_y;
    logic [56:0]   rd_prod;
    logic [22:0]   tf_x100;
    logic [bmrs_pkg::DEN_BITS-1:0] den;
    logic signed [31:0] read_val;
    logic signed [31:0] post_val;
    logic signed [32:0] sum;
    logic [31:0]   sat_sum;
    logic          out_load;

    bmrs_pkg::div_req_t div_req;
    bmrs_pkg::div_rsp_t div_rsp;

    assign in_doc   = s_axis_tdata[15:0];
    assign in_tf    = s_axis_tdata[31:16];
    assign in_len   = s_axis_tdata[55:32];
    assign in_rd    = s_axis_tdata[71:56];
    assign in_op    = bmrs_pkg::op_t'(s_axis_tuser);
    assign in_acc   = s_axis_tvalid && s_axis_tready;
    assign in_range = {9'b0, in_doc} < DOC_LIMIT;

    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idf_reg <= '0;
            iml_reg <= bmrs_pkg::IML_RESET;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == bmrs_pkg::CFG_IDF)
            begin
                idf_reg <= cfg_data[23:0];
            end
            else if (cfg_index == bmrs_pkg::CFG_IML)
            begin
                iml_reg <= cfg_data;
            end
        end
    end

    // Stores
    bmrs_ram #(.WIDTH(24), .DEPTH(MAX_DOCS)) u_len_ram (
        .clk   (clk),
        .we    (doc_we),
        .waddr (AW'(in_doc)),
        .wdata (in_len),
        .raddr (AW'(in_doc)),
        .rdata (len_q)
    );

    bmrs_ram #(.WIDTH(16), .DEPTH(MAX_DOCS)) u_rd_ram (
        .clk   (clk),
        .we    (doc_we),
        .waddr (AW'(in_doc)),
        .wdata (in_rd),
        .raddr (AW'(in_doc)),
        .rdata (rd_q)
    );

    bmrs_ram #(.WIDTH(32), .DEPTH(MAX_DOCS)) u_score_ram (
        .clk   (clk),
        .we    (score_we),
        .waddr (score_waddr),
        .wdata (score_wdata),
        .raddr (AW'(in_doc)),
        .rdata (score_q)
    );

    // Divider: den = 100*tf*2^24 + 54*2^24 + 36*ratio
    assign tf_x100 = 23'(tf_reg) * 23'd100;
    assign den     = {15'b0, tf_x100, 24'b0}
                   + 62'(64'd54 << 24)
                   + {1'b0, ratio_reg, 5'b0} + {4'b0, ratio_reg, 2'b0};

    assign div_req.start = (state_reg == bmrs_pkg::ST_DEN);
    assign div_req.tf    = tf_reg;
    assign div_req.den   = den;

    bmrs_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Readability term and final sum
    assign rd_y     = bmrs_pkg::READ_BIAS - {rd_q, 12'b0};
    assign rd_prod  = 57'(rd_y) * 57'(bmrs_pkg::RECIP_125);
    assign read_val = $signed({10'b0, rdq_reg}) - $signed(bmrs_pkg::READ_OFFS);
    assign post_val = $signed({8'b0, prod_reg[39:16]}) + read_val;
    assign sum      = {score_reg[31], score_reg} + {post_val[31], post_val};
    assign sat_sum  = (sum[32] != sum[31]) ? (sum[32] ? 32'h8000_0000 : 32'h7FFF_FFFF)
                                           : sum[31:0];

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bmrs_pkg::ST_CLEAR:
            begin
                if (clr_cnt_reg == LAST_ADDR)
                begin
                    state_next = bmrs_pkg::ST_IDLE;
                end
            end
            bmrs_pkg::ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (!in_range)
                    begin
                        state_next = bmrs_pkg::ST_DONE;
                    end
                    else
                    begin
                        unique case (in_op) inside
                            bmrs_pkg::OP_LOAD,
                            bmrs_pkg::OP_READ:  state_next = bmrs_pkg::ST_FETCH;
                            bmrs_pkg::OP_SCORE: state_next = bmrs_pkg::ST_MUL_LO;
                            default:            state_next = bmrs_pkg::ST_DONE;
                        endcase
                    end
                end
            end
            bmrs_pkg::ST_FETCH:  state_next = bmrs_pkg::ST_DONE;
            bmrs_pkg::ST_MUL_LO: state_next = bmrs_pkg::ST_MUL_HI;
            bmrs_pkg::ST_MUL_HI: state_next = bmrs_pkg::ST_DEN;
            bmrs_pkg::ST_DEN:    state_next = bmrs_pkg::ST_DIV;
            bmrs_pkg::ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    state_next = bmrs_pkg::ST_ACC;
                end
            end
            bmrs_pkg::ST_ACC:    state_next = bmrs_pkg::ST_DONE;
            bmrs_pkg::ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = bmrs_pkg::ST_IDLE;
                end
            end
            default:             state_next = bmrs_pkg::ST_CLEAR;
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        s_axis_tready = (state_reg == bmrs_pkg::ST_IDLE);
        doc_we        = (state_reg == bmrs_pkg::ST_IDLE) && s_axis_tvalid && in_range
                        && (in_op == bmrs_pkg::OP_LOAD);
        out_load      = (state_reg == bmrs_pkg::ST_DONE) && (!out_valid_reg || m_axis_tready);
        score_we      = 1'b0;
        score_waddr   = addr_reg;
        score_wdata   = sat_sum;
        unique case (state_reg)
            bmrs_pkg::ST_CLEAR:
            begin
                score_we    = 1'b1;
                score_waddr = clr_cnt_reg;
                score_wdata = '0;
            end
            bmrs_pkg::ST_ACC:
            begin
                score_we = 1'b1;
            end
            default:
            begin
                score_we = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bmrs_pkg::ST_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == bmrs_pkg::ST_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            bmrs_pkg::ST_IDLE:
            begin
                addr_reg  <= AW'(in_doc);
                tf_reg    <= in_tf;
                post_reg  <= '0;
                total_reg <= '0;
            end
            bmrs_pkg::ST_FETCH:
            begin
                total_reg <= score_q;
            end
            bmrs_pkg::ST_MUL_LO:
            begin
                len_reg      <= len_q;
                ratio_lo_reg <= 40'(len_q) * 40'(iml_reg[15:0]);
                rdq_reg      <= rd_prod[56:bmrs_pkg::RECIP_SHIFT];
                score_reg    <= score_q;
            end
            bmrs_pkg::ST_MUL_HI:
            begin
                ratio_reg <= {40'(len_reg) * 40'(iml_reg[31:16]), 16'b0}
                             + 56'(ratio_lo_reg);
            end
            bmrs_pkg::ST_DIV:
            begin
                prod_reg <= 40'(idf_reg) * 40'(div_rsp.quot);
            end
            bmrs_pkg::ST_ACC:
            begin
                post_reg  <= post_val;
                total_reg <= sat_sum;
            end
            default:
            begin
            end
        endcase
        if (out_load)
        begin
            out_data_reg <= {total_reg, post_reg};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

`default_nettype wire

/* tb/sv/tb.sv */
`timescale 1ns / 1ps

module tb;

    // operation code outside the supported set
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int         HOT_DOCS  = 1;

    typedef struct {
        logic [1:0]  op;
        logic [15:0] doc;
        logic [15:0] tf;
        logic [23:0] len;
        logic [15:0] rd;
        bit          typed;
        int          want_post;
        int          want_total;
    } posting_t;

    typedef struct {
        int post;
        int total;
    } score_pair_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = 1'b0;
    logic [31:0] cfg_data = '0;

    // predictor state
    logic [23:0] idf_q816;
    logic [31:0] inv_mean_len;
    logic [23:0] doc_len [int];
    logic [15:0] doc_read [int];
    int          doc_score [int];
    int          loaded_docs [$];

    score_pair_t pending_scores [$];
    int          errors = 0;
    int          send_idle = 0;
    int          recv_stall = 0;
    int          hold_len = 0;

    bm25_readability_scorer dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #5 clk = ~clk;

    // BM25 plus readability term added by one posting
    function automatic int posting_gain(int doc, logic [15:0] tf);
        longint unsigned ratio, den, num, q, bm;
        longint          rdn, part;
        ratio = longint'(doc_len[doc]) * longint'(inv_mean_len);
        den   = ((longint'(tf) * 100) << 24) + (longint'(54) << 24) + 36 * ratio;
        num   = (longint'(tf) * 190) << 39;
        q     = num / den;
        bm    = (longint'(idf_q816) * q) >> 15;
        rdn   = (longint'(20000) - longint'(doc_read[doc])) * 65536;
        if (rdn >= 0)
            part = rdn / 2000;
        else
            part = -((-rdn + 1999) / 2000);
        return int'(bm >> 1) + int'(part);
    endfunction

    function automatic int stored_score(int doc);
        return doc_score.exists(doc) ? doc_score[doc] : 0;
    endfunction

    // update predictor for an accepted transaction and return its result
    function automatic score_pair_t apply_posting(posting_t p);
        score_pair_t r;
        longint      sum;
        int          d;
        d = p.doc;
        r.post = 0;
        r.total = 0;
        case (p.op)
            bmrs_pkg::OP_LOAD:
            begin
                doc_len[d] = p.len;
                doc_read[d] = p.rd;
                r.total = stored_score(d);
            end
            bmrs_pkg::OP_SCORE:
            begin
                r.post = posting_gain(d, p.tf);
                sum = longint'(stored_score(d)) + longint'(r.post);
                if (sum > 64'sd2147483647)
                    sum = 64'sd2147483647;
                if (sum < -64'sd2147483648)
                    sum = -64'sd2147483648;
                doc_score[d] = int'(sum);
                r.total = int'(sum);
            end
            bmrs_pkg::OP_READ:
                r.total = stored_score(d);
            default:
                ;
        endcase
        return r;
    endfunction

    task automatic report(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // result checker
    always @(posedge clk)
    begin
        score_pair_t w;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_scores.size() == 0)
                report("unexpected result", int'(m_axis_tdata[63:32]), 0);
            else
            begin
                w = pending_scores.pop_front();
                if (int'(m_axis_tdata[31:0]) != w.post)
                    report("posting_score", int'(m_axis_tdata[31:0]), w.post);
                if (int'(m_axis_tdata[63:32]) != w.total)
                    report("total_score", int'(m_axis_tdata[63:32]), w.total);
            end
        end
    end

    // receiver: random stalls, plus long hold-offs on request
    always @(posedge clk)
    begin
        if (hold_len > 0)
        begin
            hold_len = hold_len - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(0, 99) >= recv_stall);
    end

    task automatic send(posting_t p);
        score_pair_t r;
        while ($urandom_range(0, 99) < send_idle)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= p.op;
        s_axis_tdata  <= {p.rd, p.len, p.tf, p.doc};
        do
            @(posedge clk);
        while (!s_axis_tready);
        r = apply_posting(p);
        if (p.typed)
        begin
            r.post = p.want_post;
            r.total = p.want_total;
        end
        pending_scores.push_back(r);
        if (p.op == bmrs_pkg::OP_LOAD)
            loaded_docs.push_back(p.doc);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_scores.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == bmrs_pkg::CFG_IDF)
            idf_q816 = val[23:0];
        else
            inv_mean_len = val;
    endtask

    function automatic logic [15:0] pick_tf();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 16'd0;
        if (r == 1)
            return 16'hFFFF;
        return 16'($urandom());
    endfunction

    // random posting: loads, scores of loaded documents, reads, unused codes
    function automatic posting_t random_posting(bit hot);
        posting_t p;
        int       r;
        p.typed = 1'b0;
        p.want_post = 0;
        p.want_total = 0;
        p.doc = 16'($urandom());
        p.tf  = pick_tf();
        p.len = 24'($urandom());
        p.rd  = 16'($urandom());
        r = $urandom_range(0, 99);
        if (hot)
        begin
            p.doc = 16'($urandom_range(0, HOT_DOCS - 1));
            p.op = (r < 90) ? bmrs_pkg::OP_SCORE : bmrs_pkg::OP_READ;
        end
        else if (r < 15)
            p.op = bmrs_pkg::OP_LOAD;
        else if (r < 75)
        begin
            p.op = bmrs_pkg::OP_SCORE;
            p.doc = 16'(loaded_docs[$urandom_range(0, loaded_docs.size() - 1)]);
        end
        else if (r < 92)
            p.op = bmrs_pkg::OP_READ;
        else
            p.op = OP_UNUSED;
        return p;
    endfunction

    task automatic run_phase(int n, int idle, int stall, bit hot);
        send_idle = idle;
        recv_stall = stall;
        repeat (n) send(random_posting(hot));
        drain();
    endtask

    posting_t directed [] = '{
        '{bmrs_pkg::OP_READ,  16'd0,    16'd0,    24'd0,      16'd0,     1'b1, 0, 0},
        '{OP_UNUSED,          16'hFFFF, 16'hFFFF, 24'hFFFFFF, 16'hFFFF,  1'b1, 0, 0},
        '{bmrs_pkg::OP_LOAD,  16'd0,    16'd0,    24'd0,      16'd0,     1'b1, 0, 0},
        '{bmrs_pkg::OP_LOAD,  16'hFFFF, 16'hFFFF, 24'hFFFFFF, 16'hFFFF,  1'b1, 0, 0},
        '{bmrs_pkg::OP_LOAD,  16'd1,    16'd0,    24'd1000,   16'd20000, 1'b1, 0, 0},
        '{bmrs_pkg::OP_SCORE, 16'd1,    16'd0,    24'd0,      16'd0,     1'b1, 0, 0},
        '{bmrs_pkg::OP_SCORE, 16'd0,    16'd0,    24'd0,      16'd0,     1'b1, 655360, 655360},
        '{bmrs_pkg::OP_SCORE, 16'hFFFF, 16'hFFFF, 24'hFFFFFF, 16'hFFFF,  1'b0, 0, 0},
        '{bmrs_pkg::OP_SCORE, 16'd0,    16'hFFFF, 24'd0,      16'd0,     1'b0, 0, 0},
        '{bmrs_pkg::OP_READ,  16'd0,    16'd0,    24'd0,      16'd0,     1'b0, 0, 0},
        '{OP_UNUSED,          16'd1,    16'hFFFF, 24'hFFFFFF, 16'hFFFF,  1'b1, 0, 0},
        '{bmrs_pkg::OP_READ,  16'hFFFF, 16'd0,    24'd0,      16'd0,     1'b0, 0, 0},
        '{bmrs_pkg::OP_LOAD,  16'd2,    16'hFFFF, 24'hFFFFFF, 16'hFFFF,  1'b0, 0, 0},
        '{bmrs_pkg::OP_SCORE, 16'd2,    16'd1,    24'd0,      16'd0,     1'b0, 0, 0}
    };

    initial
    begin
        posting_t p;
        idf_q816 = '0;
        inv_mean_len = bmrs_pkg::IML_RESET;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed table at reset register values
        foreach (directed[i])
            send(directed[i]);
        drain();

        // random phases across register settings and idling mixes
        write_reg(bmrs_pkg::CFG_IDF, 32'hFFFFFF);
        write_reg(bmrs_pkg::CFG_IML, 32'd0);
        run_phase(120, 0, 0, 1'b0);

        write_reg(bmrs_pkg::CFG_IDF, 32'($urandom()));
        write_reg(bmrs_pkg::CFG_IML, bmrs_pkg::IML_RESET);
        run_phase(100, 54, 0, 1'b0);
        // sender pause until every result is back
        run_phase(100, 54, 0, 1'b0);

        write_reg(bmrs_pkg::CFG_IDF, 32'($urandom()));
        write_reg(bmrs_pkg::CFG_IML, 32'hFFFFFFFF);
        hold_len = 400;
        run_phase(200, 0, 54, 1'b0);

        write_reg(bmrs_pkg::CFG_IDF, 32'($urandom()));
        write_reg(bmrs_pkg::CFG_IML, $urandom());
        run_phase(200, 24, 24, 1'b0);

        // hot document with the largest idf: drive its total to positive saturation
        write_reg(bmrs_pkg::CFG_IDF, 32'hFFFFFF);
        write_reg(bmrs_pkg::CFG_IML, 32'($urandom_range(0, 1 << 24)));
        run_phase(260, 0, 0, 1'b1);

        // zero idf, worst readability: drive one document's total negative
        write_reg(bmrs_pkg::CFG_IDF, 32'd0);
        send_idle = 0;
        recv_stall = 0;
        p = directed[0];
        p.typed = 1'b0;
        p.op = bmrs_pkg::OP_LOAD;
        p.doc = 16'd7;
        p.len = 24'($urandom());
        p.rd = 16'hFFFF;
        send(p);
        p.op = bmrs_pkg::OP_SCORE;
        repeat (60)
        begin
            p.tf = pick_tf();
            send(p);
        end
        drain();

        if (errors == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

    // run limit
    initial
    begin
        #30ms;
        $display("tb: errors");
        $finish;
    end

endmodule
